/* design/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the shell command tokenizer
// Token kinds, scanner modes, character codes and the result records that
// pass from the scanner to the output queue.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Longest supported line; positions saturate below it.
  localparam int unsigned LineMax = 4096;
  localparam int unsigned PosW    = 12;
  localparam logic [PosW-1:0] PosCap =
      (LineMax - 1 < 4095) ? PosW'(LineMax - 1) : PosW'(4095);

  // Characters with a meaning of their own.
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChBar    = 8'h7C;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;

  // Token kinds as they appear on the output.
  typedef enum logic [4:0] {
    KWord       = 5'd0,
    KEnd        = 5'd1,
    KIn         = 5'd2,
    KOut        = 5'd3,
    KOutErr     = 5'd4,
    KAppend     = 5'd5,
    KAppendErr  = 5'd6,
    KPipe       = 5'd7,
    KPipeErr    = 5'd8,
    KOr         = 5'd9,
    KAnd        = 5'd10,
    KBg         = 5'd11,
    KSemi       = 5'd12,
    KLpar       = 5'd13,
    KRpar       = 5'd14,
    KBadEscape  = 5'd15,
    KOpenQuote  = 5'd16,
    KOpenDquote = 5'd17
  } kind_e;

  // Scanner modes, one-hot.
  typedef enum logic [10:0] {
    MIdle     = 11'b000_0000_0001,
    MGt       = 11'b000_0000_0010,
    MOutSkip  = 11'b000_0000_0100,
    MAppSkip  = 11'b000_0000_1000,
    MBar      = 11'b000_0001_0000,
    MPipeSkip = 11'b000_0010_0000,
    MAmp      = 11'b000_0100_0000,
    MWord     = 11'b000_1000_0000,
    MEsc      = 11'b001_0000_0000,
    MSq       = 11'b010_0000_0000,
    MDq       = 11'b100_0000_0000
  } mode_e;

  // One token as it leaves the block.
  typedef struct packed {
    kind_e             kind;
    logic [PosW-1:0]   first_pos;
    logic [PosW-1:0]   last_pos;
    logic              last;
  } result_t;

  // Tokens caused by one character (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return is_blank(c) || (c == ChNul) || (c == ChGt) || (c == ChLt) ||
           (c == ChAmp) || (c == ChBar) || (c == ChSemi) ||
           (c == ChLpar) || (c == ChRpar);
  endfunction

endpackage

/* design/sct_lexer.sv */
// ----------------------------------------------------------------------------
// sct_lexer: scanner state and combinational token decision
// Holds the scan mode and line positions, and works out from one character
// the tokens it closes and opens, combinationally.
// ----------------------------------------------------------------------------
module sct_lexer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,   // a character transfer happens
  input  logic [7:0]                ch_i,
  output sct_pkg::step_t            step_o
);

  sct_pkg::mode_e                    mode_q, mode_d;
  logic [sct_pkg::PosW-1:0]          pos_q, pos_d;
  logic [sct_pkg::PosW-1:0]          start_q, start_d;
  logic [sct_pkg::PosW-1:0]          bend_q, bend_d;

  // Token closed by the pending mode.
  logic                              close_v;
  sct_pkg::kind_e                    close_kind;
  logic [sct_pkg::PosW-1:0]          close_end;
  // Token started afresh from the between-tokens mode.
  logic                              open_v;
  sct_pkg::kind_e                    open_kind;
  logic                              do_idle;
  logic                              ended;
  // Skip handling shared by the redirection and pipe modes.
  logic                              skip_en;
  sct_pkg::kind_e                    skip_plain;
  sct_pkg::kind_e                    skip_err;
  sct_pkg::mode_e                    skip_mode;
  logic                              blank;

  assign blank = sct_pkg::is_blank(ch_i);

  // Next-state and token decision for the current character.
  always_comb begin
    mode_d     = mode_q;
    start_d    = start_q;
    bend_d     = bend_q;
    close_v    = 1'b0;
    close_kind = sct_pkg::KWord;
    close_end  = bend_q;
    open_v     = 1'b0;
    open_kind  = sct_pkg::KWord;
    do_idle    = 1'b0;
    ended      = 1'b0;
    skip_en    = 1'b0;
    skip_plain = sct_pkg::KOut;
    skip_err   = sct_pkg::KOutErr;
    skip_mode  = sct_pkg::MOutSkip;

    unique case (mode_q) inside
      sct_pkg::MIdle: begin
        do_idle = 1'b1;
      end
      sct_pkg::MGt: begin
        if (ch_i == sct_pkg::ChGt) begin
          bend_d = pos_q;
          mode_d = sct_pkg::MAppSkip;
        end else begin
          skip_en = 1'b1;
        end
      end
      sct_pkg::MOutSkip: begin
        skip_en = 1'b1;
      end
      sct_pkg::MAppSkip: begin
        skip_en    = 1'b1;
        skip_plain = sct_pkg::KAppend;
        skip_err   = sct_pkg::KAppendErr;
        skip_mode  = sct_pkg::MAppSkip;
      end
      sct_pkg::MBar: begin
        if (ch_i == sct_pkg::ChBar) begin
          close_v    = 1'b1;
          close_kind = sct_pkg::KOr;
          close_end  = pos_q;
          mode_d     = sct_pkg::MIdle;
        end else begin
          skip_en    = 1'b1;
          skip_plain = sct_pkg::KPipe;
          skip_err   = sct_pkg::KPipeErr;
          skip_mode  = sct_pkg::MPipeSkip;
        end
      end
      sct_pkg::MPipeSkip: begin
        skip_en    = 1'b1;
        skip_plain = sct_pkg::KPipe;
        skip_err   = sct_pkg::KPipeErr;
        skip_mode  = sct_pkg::MPipeSkip;
      end
      sct_pkg::MAmp: begin
        mode_d  = sct_pkg::MIdle;
        close_v = 1'b1;
        if (ch_i == sct_pkg::ChAmp) begin
          close_kind = sct_pkg::KAnd;
          close_end  = pos_q;
        end else begin
          close_kind = sct_pkg::KBg;
          do_idle    = 1'b1;
        end
      end
      sct_pkg::MWord: begin
        if (sct_pkg::ends_word(ch_i)) begin
          close_v    = 1'b1;
          close_kind = sct_pkg::KWord;
          mode_d     = sct_pkg::MIdle;
          do_idle    = 1'b1;
        end else begin
          bend_d = pos_q;
          if (ch_i == sct_pkg::ChBslash) begin
            mode_d = sct_pkg::MEsc;
          end else if (ch_i == sct_pkg::ChQuote) begin
            mode_d = sct_pkg::MSq;
          end else if (ch_i == sct_pkg::ChDquote) begin
            mode_d = sct_pkg::MDq;
          end
        end
      end
      sct_pkg::MEsc: begin
        if (ch_i == sct_pkg::ChNul) begin
          close_v    = 1'b1;
          close_kind = sct_pkg::KBadEscape;
          close_end  = pos_q;
          ended      = 1'b1;
        end else begin
          bend_d = pos_q;
          mode_d = sct_pkg::MWord;
        end
      end
      sct_pkg::MSq, sct_pkg::MDq: begin
        if (ch_i == sct_pkg::ChNul) begin
          close_v    = 1'b1;
          close_kind = (mode_q == sct_pkg::MSq) ? sct_pkg::KOpenQuote
                                                : sct_pkg::KOpenDquote;
          close_end  = pos_q;
          ended      = 1'b1;
        end else begin
          bend_d = pos_q;
          if ((mode_q == sct_pkg::MSq && ch_i == sct_pkg::ChQuote) ||
              (mode_q == sct_pkg::MDq && ch_i == sct_pkg::ChDquote)) begin
            mode_d = sct_pkg::MWord;
          end
        end
      end
      default: begin
        mode_d  = sct_pkg::MIdle;
        do_idle = 1'b1;
      end
    endcase

    // Blanks after > >> or | are absorbed; & picks the error variant.
    if (skip_en) begin
      if (blank) begin
        bend_d = pos_q;
        mode_d = skip_mode;
      end else if (ch_i == sct_pkg::ChAmp) begin
        close_v    = 1'b1;
        close_kind = skip_err;
        close_end  = pos_q;
        mode_d     = sct_pkg::MIdle;
      end else begin
        close_v    = 1'b1;
        close_kind = skip_plain;
        mode_d     = sct_pkg::MIdle;
        do_idle    = 1'b1;
      end
    end

    // The character is lexed afresh from the between-tokens mode.
    if (do_idle && !blank) begin
      start_d = pos_q;
      bend_d  = pos_q;
      mode_d  = sct_pkg::MIdle;
      unique case (ch_i)
        sct_pkg::ChNul: begin
          open_v    = 1'b1;
          open_kind = sct_pkg::KEnd;
          ended     = 1'b1;
        end
        sct_pkg::ChGt:     mode_d = sct_pkg::MGt;
        sct_pkg::ChBar:    mode_d = sct_pkg::MBar;
        sct_pkg::ChAmp:    mode_d = sct_pkg::MAmp;
        sct_pkg::ChLt: begin
          open_v    = 1'b1;
          open_kind = sct_pkg::KIn;
        end
        sct_pkg::ChSemi: begin
          open_v    = 1'b1;
          open_kind = sct_pkg::KSemi;
        end
        sct_pkg::ChLpar: begin
          open_v    = 1'b1;
          open_kind = sct_pkg::KLpar;
        end
        sct_pkg::ChRpar: begin
          open_v    = 1'b1;
          open_kind = sct_pkg::KRpar;
        end
        sct_pkg::ChBslash: mode_d = sct_pkg::MEsc;
        sct_pkg::ChQuote:  mode_d = sct_pkg::MSq;
        sct_pkg::ChDquote: mode_d = sct_pkg::MDq;
        default:           mode_d = sct_pkg::MWord;
      endcase
    end

    // A zero byte returns the line to its start; otherwise count up.
    if (ended) begin
      mode_d  = sct_pkg::MIdle;
      pos_d   = '0;
      start_d = '0;
      bend_d  = '0;
    end else if (pos_q < sct_pkg::PosCap) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = sct_pkg::PosCap;
    end
  end

  // Pack the tokens of this character in order, marking the final one.
  always_comb begin
    step_o = '0;
    if (close_v) begin
      step_o.r0.kind      = close_kind;
      step_o.r0.first_pos = start_q;
      step_o.r0.last_pos  = close_end;
      step_o.r0.last      = !open_v;
      step_o.r1.kind      = open_kind;
      step_o.r1.first_pos = pos_q;
      step_o.r1.last_pos  = pos_q;
      step_o.r1.last      = 1'b1;
      step_o.count        = open_v ? 2'd2 : 2'd1;
    end else begin
      step_o.r0.kind      = open_kind;
      step_o.r0.first_pos = pos_q;
      step_o.r0.last_pos  = pos_q;
      step_o.r0.last      = 1'b1;
      step_o.r1.kind      = open_kind;
      step_o.r1.first_pos = pos_q;
      step_o.r1.last_pos  = pos_q;
      step_o.r1.last      = 1'b1;
      step_o.count        = open_v ? 2'd1 : 2'd0;
    end
    if (!step_i) begin
      step_o.count = 2'd0;
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sct_pkg::MIdle;
      pos_q   <= '0;
      start_q <= '0;
      bend_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      bend_q  <= bend_d;
    end
  end

endmodule

/* design/shell_command_tokenizer.sv */
// ----------------------------------------------------------------------------
// shell_command_tokenizer: streaming command-line lexer
// Takes one character per transfer and produces tokens with their kind and
// first and last line positions.
//
//   Channel  Dir  tdata                                tuser       tlast
//   s_axis   in   [7:0] ch                             -           -
//   m_axis   out  [11:0] first_pos, [23:12] last_pos   [4:0] kind  last token
//
// A character is decided in the cycle it is taken; its tokens (up to two)
// land in a four-entry output queue and leave one per cycle unless stalled.
// Input is taken every cycle while the queue has room for two tokens.
// A two-token character needs two output transfers, so without output stalls
// the sustained rate is one character per cycle if each gives at most one.
// Reset returns the scanner to the start of a line and empties the queue.
// ----------------------------------------------------------------------------
module shell_command_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] first_pos, [23:12] last_pos
  output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
  output logic        m_axis_tlast
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  sct_pkg::step_t      step;
  logic                in_xfer;
  logic                out_xfer;
  sct_pkg::result_t    q_mem [QDepth];
  logic [QPtrW-1:0]    wr_q, wr_d;
  logic [QPtrW-1:0]    rd_q, rd_d;
  logic [QCntW-1:0]    cnt_q, cnt_d;
  sct_pkg::result_t    head;

  // Room for two tokens guarantees any character can be taken.
  assign s_axis_tready = (cnt_q <= QCntW'(QDepth - 2));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  sct_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .ch_i   (s_axis_tdata),
    .step_o (step)
  );

  // Queue pointer and fill bookkeeping.
  always_comb begin
    wr_d  = wr_q + QPtrW'(step.count);
    rd_d  = rd_q + QPtrW'(out_xfer);
    cnt_d = cnt_q + QCntW'(step.count) - QCntW'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    if (step.count != 2'd0) begin
      q_mem[wr_q] <= step.r0;
    end
    if (step.count == 2'd2) begin
      q_mem[wr_q + 1'b1] <= step.r1;
    end
  end

  // Output side.
  assign head          = q_mem[rd_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {head.last_pos, head.first_pos};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule
